// File: hw/rtl/lcvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_pkg: shared definitions for the line clip and viewport map block
// register indexes, reset values and default widths
// ----------------------------------------------------------------------------
package lcvm_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_INDEX_W    = 3;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIN_X_MIN  = 3'd0,
        REG_WIN_X_MAX  = 3'd1,
        REG_WIN_Y_MIN  = 3'd2,
        REG_WIN_Y_MAX  = 3'd3,
        REG_VIEW_X_MIN = 3'd4,
        REG_VIEW_X_MAX = 3'd5,
        REG_VIEW_Y_MIN = 3'd6,
        REG_VIEW_Y_MAX = 3'd7
    } cfg_reg_t;

    localparam int EDGE_MIN_RST = 0;
    localparam int EDGE_MAX_RST = 719;

endpackage

// File: hw/rtl/line_clip_viewport_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_clip_viewport_map: liang-barsky segment clipper with viewport mapping
// clips one segment per item against the window and maps it to the viewport
// ----------------------------------------------------------------------------
// The block takes one segment per cycle and gives one result per segment, in
// order; throughput is one item per clock while m_tready does not stall the
// output. The pipeline has 3*COORD_BITS + FRAC_BITS + 9 register stages (61 at
// the defaults): two rows of division cells, COORD_BITS+FRAC_BITS+1 cells for
// the four boundary ratios and 2*COORD_BITS+2 cells for the four viewport
// offsets, one quotient bit per cell, plus six single stages around them. Each
// stage holds its item until the next one takes it, so bubbles close up and the
// input keeps taking items while a result waits at the output, until every
// stage is full. Configuration is read live, so write it only while no item is
// in flight. Entry and exit parameters are unsigned Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
module line_clip_viewport_map #(
    parameter int COORD_BITS = lcvm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lcvm_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // slave side: start_x, start_y, end_x, end_y
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // master side: out_start_x, out_start_y, out_end_x, out_end_y
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((4*COORD_BITS+7)/8)*8-1:0]       m_tdata,
    // master side: visible
    output logic                                    m_tuser,
    // configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [lcvm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [COORD_BITS-1:0]                   cfg_wdata
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int DW    = C + 1;          // signed difference
    localparam int T_W   = F + 1;          // t0, t1
    localparam int R_W   = F + 3;          // signed boundary ratio
    localparam int N1_W  = C + F + 1;      // ratio dividend
    localparam int NW    = C + F + 2;      // signed offset from window edge
    localparam int MW    = C + F + 1;      // its magnitude
    localparam int XW    = MW + C;         // scaled magnitude
    localparam int ZW    = 2 * C + 2;      // offset dividend
    localparam int OW    = ZW + 2;         // offset plus viewport edge
    localparam int BUS_W = ((4 * C + 7) / 8) * 8;
    localparam int S1_W  = 2 * C + 2 * DW + 12;
    localparam int S2_W  = 5;

    localparam logic [N1_W-1:0]       R_SAT  = N1_W'(2**F + 1);
    localparam logic signed [R_W-1:0] R_ONE  = R_W'(2**F);
    localparam logic signed [OW-1:0]  V_MAX  = OW'(2**(C-1) - 1);
    localparam logic signed [OW-1:0]  V_MIN  = OW'(-(2**(C-1)));

    // configuration registers
    logic signed [C-1:0] win_x_min_reg, win_x_max_reg, win_y_min_reg, win_y_max_reg;
    logic signed [C-1:0] view_x_min_reg, view_x_max_reg, view_y_min_reg, view_y_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_min_reg  <= C'(lcvm_pkg::EDGE_MIN_RST);
            win_x_max_reg  <= C'(lcvm_pkg::EDGE_MAX_RST);
            win_y_min_reg  <= C'(lcvm_pkg::EDGE_MIN_RST);
            win_y_max_reg  <= C'(lcvm_pkg::EDGE_MAX_RST);
            view_x_min_reg <= C'(lcvm_pkg::EDGE_MIN_RST);
            view_x_max_reg <= C'(lcvm_pkg::EDGE_MAX_RST);
            view_y_min_reg <= C'(lcvm_pkg::EDGE_MIN_RST);
            view_y_max_reg <= C'(lcvm_pkg::EDGE_MAX_RST);
        end
        else if (cfg_wr_en)
        begin
            case (lcvm_pkg::cfg_reg_t'(cfg_index))
                lcvm_pkg::REG_WIN_X_MIN:  win_x_min_reg  <= cfg_wdata;
                lcvm_pkg::REG_WIN_X_MAX:  win_x_max_reg  <= cfg_wdata;
                lcvm_pkg::REG_WIN_Y_MIN:  win_y_min_reg  <= cfg_wdata;
                lcvm_pkg::REG_WIN_Y_MAX:  win_y_max_reg  <= cfg_wdata;
                lcvm_pkg::REG_VIEW_X_MIN: view_x_min_reg <= cfg_wdata;
                lcvm_pkg::REG_VIEW_X_MAX: view_x_max_reg <= cfg_wdata;
                lcvm_pkg::REG_VIEW_Y_MIN: view_y_min_reg <= cfg_wdata;
                lcvm_pkg::REG_VIEW_Y_MAX: view_y_max_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // window and viewport spans, shared by the mapping stages
    logic signed [DW-1:0] ww_x, ww_y, vw_x, vw_y;
    logic [C-1:0]         ww_x_mag, ww_y_mag, vw_x_mag, vw_y_mag;

    assign ww_x = {win_x_max_reg[C-1], win_x_max_reg} - {win_x_min_reg[C-1], win_x_min_reg};
    assign ww_y = {win_y_max_reg[C-1], win_y_max_reg} - {win_y_min_reg[C-1], win_y_min_reg};
    assign vw_x = {view_x_max_reg[C-1], view_x_max_reg}
                - {view_x_min_reg[C-1], view_x_min_reg};
    assign vw_y = {view_y_max_reg[C-1], view_y_max_reg}
                - {view_y_min_reg[C-1], view_y_min_reg};

    logic [DW-1:0] ww_x_neg, ww_y_neg, vw_x_neg, vw_y_neg;
    assign ww_x_neg = -ww_x;
    assign ww_y_neg = -ww_y;
    assign vw_x_neg = -vw_x;
    assign vw_y_neg = -vw_y;
    assign ww_x_mag = ww_x[DW-1] ? ww_x_neg[C-1:0] : ww_x[C-1:0];
    assign ww_y_mag = ww_y[DW-1] ? ww_y_neg[C-1:0] : ww_y[C-1:0];
    assign vw_x_mag = vw_x[DW-1] ? vw_x_neg[C-1:0] : vw_x[C-1:0];
    assign vw_y_mag = vw_y[DW-1] ? vw_y_neg[C-1:0] : vw_y[C-1:0];

    // stage ready chain, from the output back to the input
    logic f_ready, d1_in_ready, c_ready, p_ready, m_ready, z_ready, d2_in_ready, o_ready;
    logic f_valid_reg, d1_out_valid, c_valid_reg, p_valid_reg, m_valid_reg, z_valid_reg;
    logic d2_out_valid, o_valid_reg;

    // ------------------------------------------------------------------
    // front stage: boundary terms p and q for left, right, bottom, top
    // ------------------------------------------------------------------
    logic signed [C-1:0]  in_x0, in_y0, in_x1, in_y1;
    logic signed [DW-1:0] in_dx, in_dy;
    logic signed [DW-1:0] bp [4];
    logic signed [DW-1:0] bq [4];
    logic [DW-1:0]        bp_neg [4];
    logic [DW-1:0]        bq_neg [4];
    logic [C-1:0]         bp_mag [4];
    logic [C-1:0]         bq_mag [4];
    logic [3:0][N1_W-1:0] f_acc_next;
    logic [3:0][C-1:0]    f_div_next;
    logic [S1_W-1:0]      f_side_next;
    logic [3:0]           fl_pzero, fl_pneg, fl_qneg;

    logic [3:0][N1_W-1:0] f_acc_reg;
    logic [3:0][C-1:0]    f_div_reg;
    logic [S1_W-1:0]      f_side_reg;

    assign in_x0 = s_tdata[C-1:0];
    assign in_y0 = s_tdata[2*C-1:C];
    assign in_x1 = s_tdata[3*C-1:2*C];
    assign in_y1 = s_tdata[4*C-1:3*C];
    assign in_dx = {in_x1[C-1], in_x1} - {in_x0[C-1], in_x0};
    assign in_dy = {in_y1[C-1], in_y1} - {in_y0[C-1], in_y0};

    always_comb
    begin
        bp[0] = -in_dx;
        bq[0] = {in_x0[C-1], in_x0} - {win_x_min_reg[C-1], win_x_min_reg};
        bp[1] = in_dx;
        bq[1] = {win_x_max_reg[C-1], win_x_max_reg} - {in_x0[C-1], in_x0};
        bp[2] = -in_dy;
        bq[2] = {in_y0[C-1], in_y0} - {win_y_min_reg[C-1], win_y_min_reg};
        bp[3] = in_dy;
        bq[3] = {win_y_max_reg[C-1], win_y_max_reg} - {in_y0[C-1], in_y0};
        for (int k = 0; k < 4; k++)
        begin
            bp_neg[k]   = -bp[k];
            bq_neg[k]   = -bq[k];
            bp_mag[k]   = bp[k][DW-1] ? bp_neg[k][C-1:0] : bp[k][C-1:0];
            bq_mag[k]   = bq[k][DW-1] ? bq_neg[k][C-1:0] : bq[k][C-1:0];
            fl_pzero[k] = (bp[k] == '0);
            fl_pneg[k]  = bp[k][DW-1];
            fl_qneg[k]  = bq[k][DW-1];
            // |q| * one plus half of |p|, so the quotient rounds to nearest
            f_acc_next[k] = N1_W'({bq_mag[k], {F{1'b0}}}) + N1_W'(bp_mag[k] >> 1);
            f_div_next[k] = bp_mag[k];
        end
        f_side_next = {fl_qneg, fl_pneg, fl_pzero, in_dy, in_dx, in_y0, in_x0};
    end

    assign f_ready  = !f_valid_reg || d1_in_ready;
    assign s_tready = f_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (f_ready)
        begin
            f_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_ready && s_tvalid)
        begin
            f_acc_reg  <= f_acc_next;
            f_div_reg  <= f_div_next;
            f_side_reg <= f_side_next;
        end
    end

    // ------------------------------------------------------------------
    // boundary ratio division
    // ------------------------------------------------------------------
    logic [3:0][N1_W-1:0] d1_quo;
    logic [S1_W-1:0]      d1_side;

    lcvm_div_chain #(
        .LANES  (4),
        .DIV_W  (C),
        .ACC_W  (N1_W),
        .SIDE_W (S1_W)
    ) u_ratio_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (f_valid_reg),
        .in_ready     (d1_in_ready),
        .in_dividend  (f_acc_reg),
        .in_divisor   (f_div_reg),
        .in_side      (f_side_reg),
        .out_valid    (d1_out_valid),
        .out_ready    (c_ready),
        .out_quotient (d1_quo),
        .out_side     (d1_side)
    );

    // ------------------------------------------------------------------
    // clip stage: walk the four boundaries in order, narrowing t0 and t1
    // ------------------------------------------------------------------
    logic signed [C-1:0]  d1_x0, d1_y0;
    logic signed [DW-1:0] d1_dx, d1_dy;
    logic [3:0]           d1_pzero, d1_pneg, d1_qneg;
    logic [F+1:0]         cl_m [4];
    logic signed [R_W-1:0] cl_r [4];
    logic signed [R_W-1:0] cl_t0, cl_t1;
    logic                  cl_rej;

    assign d1_x0    = d1_side[C-1:0];
    assign d1_y0    = d1_side[2*C-1:C];
    assign d1_dx    = d1_side[2*C+DW-1:2*C];
    assign d1_dy    = d1_side[2*C+2*DW-1:2*C+DW];
    assign d1_pzero = d1_side[2*C+2*DW+3:2*C+2*DW];
    assign d1_pneg  = d1_side[2*C+2*DW+7:2*C+2*DW+4];
    assign d1_qneg  = d1_side[2*C+2*DW+11:2*C+2*DW+8];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            // ratios past one and a bit compare the same as any larger value
            cl_m[k] = (d1_quo[k] > R_SAT) ? R_SAT[F+1:0] : d1_quo[k][F+1:0];
            cl_r[k] = (d1_qneg[k] != d1_pneg[k]) ? -$signed({1'b0, cl_m[k]})
                                                 :  $signed({1'b0, cl_m[k]});
        end
    end

    always_comb
    begin
        cl_t0  = '0;
        cl_t1  = R_ONE;
        cl_rej = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!cl_rej)
            begin
                if (d1_pzero[k])
                begin
                    // parallel to this edge: out only when wholly outside it
                    cl_rej = d1_qneg[k];
                end
                else if (d1_pneg[k])
                begin
                    if (cl_r[k] > cl_t1)
                        cl_rej = 1'b1;
                    else if (cl_r[k] > cl_t0)
                        cl_t0 = cl_r[k];
                end
                else
                begin
                    if (cl_r[k] < cl_t0)
                        cl_rej = 1'b1;
                    else if (cl_r[k] < cl_t1)
                        cl_t1 = cl_r[k];
                end
            end
        end
    end

    logic [T_W-1:0]       c_t0_reg, c_t1_reg;
    logic                 c_vis_reg;
    logic signed [C-1:0]  c_x0_reg, c_y0_reg;
    logic signed [DW-1:0] c_dx_reg, c_dy_reg;

    assign c_ready = !c_valid_reg || p_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= d1_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && d1_out_valid)
        begin
            c_t0_reg  <= cl_t0[T_W-1:0];
            c_t1_reg  <= cl_t1[T_W-1:0];
            c_vis_reg <= !cl_rej;
            c_x0_reg  <= d1_x0;
            c_y0_reg  <= d1_y0;
            c_dx_reg  <= d1_dx;
            c_dy_reg  <= d1_dy;
        end
    end

    // ------------------------------------------------------------------
    // point stage: clipped endpoint relative to the window edge
    // lanes: start x, start y, end x, end y
    // ------------------------------------------------------------------
    logic signed [DW-1:0] pt_base [4];
    logic [T_W-1:0]       pt_t    [4];
    logic signed [DW-1:0] pt_d    [4];
    logic signed [NW-1:0] pt_num  [4];
    logic [3:0][NW-1:0]   p_num_reg;
    logic                 p_vis_reg;

    always_comb
    begin
        pt_base[0] = {c_x0_reg[C-1], c_x0_reg} - {win_x_min_reg[C-1], win_x_min_reg};
        pt_base[1] = {c_y0_reg[C-1], c_y0_reg} - {win_y_min_reg[C-1], win_y_min_reg};
        pt_base[2] = pt_base[0];
        pt_base[3] = pt_base[1];
        pt_t[0]    = c_t0_reg;
        pt_t[1]    = c_t0_reg;
        pt_t[2]    = c_t1_reg;
        pt_t[3]    = c_t1_reg;
        pt_d[0]    = c_dx_reg;
        pt_d[1]    = c_dy_reg;
        pt_d[2]    = c_dx_reg;
        pt_d[3]    = c_dy_reg;
        for (int k = 0; k < 4; k++)
        begin
            pt_num[k] = $signed({pt_base[k][DW-1], pt_base[k], {F{1'b0}}})
                      + NW'($signed({1'b0, pt_t[k]})) * NW'(pt_d[k]);
        end
    end

    assign p_ready = !p_valid_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_ready)
        begin
            p_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && c_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_num_reg[k] <= pt_num[k];
            end
            p_vis_reg <= c_vis_reg;
        end
    end

    // ------------------------------------------------------------------
    // scale stage: |offset| times |viewport span|, sign kept apart
    // ------------------------------------------------------------------
    logic [NW-1:0]  ms_neg_num [4];
    logic [MW-1:0]  ms_mag     [4];
    logic [XW-1:0]  ms_x       [4];
    logic [3:0]     ms_neg;
    logic [3:0][XW-1:0] m_x_reg;
    logic [3:0]     m_neg_reg;
    logic           m_vis_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ms_neg_num[k] = -p_num_reg[k];
            ms_mag[k]     = p_num_reg[k][NW-1] ? ms_neg_num[k][MW-1:0] : p_num_reg[k][MW-1:0];
            if ((k % 2) == 0)
            begin
                ms_x[k]   = XW'(ms_mag[k]) * XW'(vw_x_mag);
                ms_neg[k] = p_num_reg[k][NW-1] ^ vw_x[DW-1] ^ ww_x[DW-1];
            end
            else
            begin
                ms_x[k]   = XW'(ms_mag[k]) * XW'(vw_y_mag);
                ms_neg[k] = p_num_reg[k][NW-1] ^ vw_y[DW-1] ^ ww_y[DW-1];
            end
        end
    end

    assign m_ready = !m_valid_reg || z_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_ready)
        begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ready && p_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                m_x_reg[k] <= ms_x[k];
            end
            m_neg_reg <= ms_neg;
            m_vis_reg <= p_vis_reg;
        end
    end

    // ------------------------------------------------------------------
    // rounding stage: add half the divisor, drop the fraction bits
    // dividing by span * one equals dividing by one, then by span
    // ------------------------------------------------------------------
    logic [XW:0]         zs_sum [4];
    logic [C-1:0]        zs_div [4];
    logic [3:0][ZW-1:0]  z_acc_reg;
    logic [3:0][C-1:0]   z_div_reg;
    logic [S2_W-1:0]     z_side_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            zs_div[k] = ((k % 2) == 0) ? ww_x_mag : ww_y_mag;
            zs_sum[k] = (XW+1)'(m_x_reg[k]) + ((XW+1)'(zs_div[k]) << (F - 1));
        end
    end

    assign z_ready = !z_valid_reg || d2_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_valid_reg <= 1'b0;
        end
        else if (z_ready)
        begin
            z_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (z_ready && m_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                z_acc_reg[k] <= zs_sum[k][XW:F];
                z_div_reg[k] <= zs_div[k];
            end
            z_side_reg <= {m_vis_reg, m_neg_reg};
        end
    end

    // ------------------------------------------------------------------
    // viewport offset division
    // ------------------------------------------------------------------
    logic [3:0][ZW-1:0] d2_quo;
    logic [S2_W-1:0]    d2_side;

    lcvm_div_chain #(
        .LANES  (4),
        .DIV_W  (C),
        .ACC_W  (ZW),
        .SIDE_W (S2_W)
    ) u_offset_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (z_valid_reg),
        .in_ready     (d2_in_ready),
        .in_dividend  (z_acc_reg),
        .in_divisor   (z_div_reg),
        .in_side      (z_side_reg),
        .out_valid    (d2_out_valid),
        .out_ready    (o_ready),
        .out_quotient (d2_quo),
        .out_side     (d2_side)
    );

    // ------------------------------------------------------------------
    // output stage: sign, add viewport edge, saturate, zero a hidden segment;
    // doubles as the output register towards the master side
    logic signed [ZW:0]   os_off  [4];
    logic signed [OW-1:0] os_sum  [4];
    logic signed [C-1:0]  os_vmin [4];
    logic                 os_zero [4];
    logic [3:0][C-1:0]    os_coord;
    logic [3:0][C-1:0]    o_coord_reg;
    logic                 o_vis_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            os_vmin[k] = ((k % 2) == 0) ? view_x_min_reg : view_y_min_reg;
            os_zero[k] = ((k % 2) == 0) ? (ww_x == '0) : (ww_y == '0);
            // zero-size window axis: no scale, the point lands on the edge
            if (os_zero[k])
                os_off[k] = '0;
            else if (d2_side[k])
                os_off[k] = -$signed({1'b0, d2_quo[k]});
            else
                os_off[k] = $signed({1'b0, d2_quo[k]});
            os_sum[k] = OW'(os_vmin[k]) + OW'(os_off[k]);
            if (!d2_side[4])
                os_coord[k] = '0;
            else if (os_sum[k] > V_MAX)
                os_coord[k] = V_MAX[C-1:0];
            else if (os_sum[k] < V_MIN)
                os_coord[k] = V_MIN[C-1:0];
            else
                os_coord[k] = os_sum[k][C-1:0];
        end
    end

    assign o_ready = !o_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= d2_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && d2_out_valid)
        begin
            o_coord_reg <= os_coord;
            o_vis_reg   <= d2_side[4];
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = BUS_W'(o_coord_reg);
    assign m_tuser  = o_vis_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a hidden segment carries no coordinates
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && !o_vis_reg) |-> (o_coord_reg == '0))
        else $error("hidden segment with non-zero coordinates");

    // a visible segment keeps its entry no later than its exit
    a_t_order: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_vis_reg) |-> (c_t0_reg <= c_t1_reg))
        else $error("entry parameter beyond exit parameter");

    // exit parameter never runs past the segment end
    a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (c_t1_reg <= T_W'(2**F)))
        else $error("exit parameter above one");

    // an empty front stage always takes the next item
    a_front_free: assert property (@(posedge clk) disable iff (!rst_n)
        !f_valid_reg |-> s_tready)
        else $error("input stalled with front stage empty");

endmodule

// File: hw/rtl/lcvm_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_div_cell: one restoring division step on several lanes
// shifts one dividend bit into the remainder and one quotient bit out
// ----------------------------------------------------------------------------
module lcvm_div_cell #(
    parameter int LANES  = 4,
    parameter int DIV_W  = 12,
    parameter int ACC_W  = 29,
    parameter int SIDE_W = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [LANES-1:0][DIV_W-1:0]        in_rem,
    input  logic [LANES-1:0][ACC_W-1:0]        in_acc,
    input  logic [LANES-1:0][DIV_W-1:0]        in_div,
    input  logic [SIDE_W-1:0]                  in_side,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [LANES-1:0][DIV_W-1:0]        out_rem,
    output logic [LANES-1:0][ACC_W-1:0]        out_acc,
    output logic [LANES-1:0][DIV_W-1:0]        out_div,
    output logic [SIDE_W-1:0]                  out_side
);

    logic                          valid_reg;
    logic [LANES-1:0][DIV_W-1:0]   rem_reg;
    logic [LANES-1:0][DIV_W-1:0]   rem_next;
    logic [LANES-1:0][ACC_W-1:0]   acc_reg;
    logic [LANES-1:0][ACC_W-1:0]   acc_next;
    logic [LANES-1:0][DIV_W-1:0]   div_reg;
    logic [SIDE_W-1:0]             side_reg;
    logic [LANES-1:0][DIV_W:0]     shifted;
    logic [LANES-1:0][DIV_W:0]     diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            shifted[l] = {in_rem[l], in_acc[l][ACC_W-1]};
            diff[l]    = shifted[l] - {1'b0, in_div[l]};
            if (shifted[l] >= {1'b0, in_div[l]})
            begin
                rem_next[l] = diff[l][DIV_W-1:0];
                acc_next[l] = {in_acc[l][ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = shifted[l][DIV_W-1:0];
                acc_next[l] = {in_acc[l][ACC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/lcvm_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_div_chain: row of division cells, one quotient bit per cell
// gives floor(dividend / divisor) on each lane after ACC_W cells
// ----------------------------------------------------------------------------
module lcvm_div_chain #(
    parameter int LANES  = 4,
    parameter int DIV_W  = 12,
    parameter int ACC_W  = 29,
    parameter int SIDE_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LANES-1:0][ACC_W-1:0]   in_dividend,
    input  logic [LANES-1:0][DIV_W-1:0]   in_divisor,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LANES-1:0][ACC_W-1:0]   out_quotient,
    output logic [SIDE_W-1:0]             out_side
);

    logic [ACC_W:0]                             valid_w;
    logic [ACC_W:0]                             ready_w;
    logic [ACC_W:0][LANES-1:0][DIV_W-1:0]       rem_w;
    logic [ACC_W:0][LANES-1:0][ACC_W-1:0]       acc_w;
    logic [ACC_W:0][LANES-1:0][DIV_W-1:0]       div_w;
    logic [ACC_W:0][SIDE_W-1:0]                 side_w;

    assign valid_w[0] = in_valid;
    assign in_ready   = ready_w[0];
    assign rem_w[0]   = '0;
    assign acc_w[0]   = in_dividend;
    assign div_w[0]   = in_divisor;
    assign side_w[0]  = in_side;

    for (genvar i = 0; i < ACC_W; i++)
    begin : g_cell
        lcvm_div_cell #(
            .LANES  (LANES),
            .DIV_W  (DIV_W),
            .ACC_W  (ACC_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_rem    (rem_w[i]),
            .in_acc    (acc_w[i]),
            .in_div    (div_w[i]),
            .in_side   (side_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_acc   (acc_w[i+1]),
            .out_div   (div_w[i+1]),
            .out_side  (side_w[i+1])
        );
    end

    assign out_valid      = valid_w[ACC_W];
    assign ready_w[ACC_W] = out_ready;
    assign out_quotient   = acc_w[ACC_W];
    assign out_side       = side_w[ACC_W];

endmodule
